// ----- design/csi_tbu_pkg.sv -----
// csi_tbu_pkg: types, constants and index helpers for the ten-bit sample unpacker
// used by the csr, core, queue and top-level files, depends on nothing

package csi_tbu_pkg;

   localparam int SAMPLE_BITS  = 10;
   localparam int WORD_BITS    = 16;
   localparam int MAX_ANTENNAS = 3;
   localparam int MAX_TONES    = 114;
   localparam int WINDOW_BITS  = 25;
   localparam int FILL_BITS    = 5;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = 2;
   localparam int QCNT_BITS    = 3;
   localparam int ADDR_BITS    = 4;
   localparam int DATA_BITS    = 32;

   localparam logic [1:0] RESET_RX_ANTENNAS = 2'd1;
   localparam logic [1:0] RESET_TX_ANTENNAS = 2'd1;
   localparam logic [6:0] RESET_TONE_COUNT  = 7'd114;

   typedef enum logic [1:0] {
      REG_RX_ANTENNAS = 2'd0,
      REG_TX_ANTENNAS = 2'd1,
      REG_TONE_COUNT  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [1:0] rx_antennas;
      logic [1:0] tx_antennas;
      logic [6:0] tone_count;
   } cfg_type;

   typedef struct packed {
      logic       part;
      logic [1:0] rx;
      logic [1:0] tx;
      logic [6:0] tone;
   } index_type;

   typedef struct packed {
      logic signed [9:0] sample_value;
      logic              is_real_part;
      logic [1:0]        rx_index;
      logic [1:0]        tx_index;
      logic [6:0]        tone_index;
      logic              last_of_packet;
   } result_type;

   typedef struct packed {
      logic       push0;
      logic       push1;
      result_type item0;
      result_type item1;
   } push_type;

   function automatic logic [2:0] limit_antennas(input logic [1:0] v);
      logic [2:0] ext;
      logic [2:0] res;
      ext = {1'b0, v};
      if (ext == 3'd0) res = 3'd1;
      else if (ext > 3'(MAX_ANTENNAS)) res = 3'(MAX_ANTENNAS);
      else res = ext;
      return res;
   endfunction

   function automatic logic [7:0] limit_tones(input logic [6:0] v);
      logic [7:0] ext;
      logic [7:0] res;
      ext = {1'b0, v};
      if (ext == 8'd0) res = 8'd1;
      else if (ext > 8'(MAX_TONES)) res = 8'(MAX_TONES);
      else res = ext;
      return res;
   endfunction

   function automatic logic rx_wraps(input index_type idx, input cfg_type cfg);
      return ({1'b0, idx.rx} + 3'd1) >= limit_antennas(cfg.rx_antennas);
   endfunction

   function automatic logic tx_wraps(input index_type idx, input cfg_type cfg);
      return ({1'b0, idx.tx} + 3'd1) >= limit_antennas(cfg.tx_antennas);
   endfunction

   function automatic logic tone_wraps(input index_type idx, input cfg_type cfg);
      return ({1'b0, idx.tone} + 8'd1) >= limit_tones(cfg.tone_count);
   endfunction

   function automatic logic is_last(input index_type idx, input cfg_type cfg);
      return idx.part && rx_wraps(idx, cfg) && tx_wraps(idx, cfg) && tone_wraps(idx, cfg);
   endfunction

   function automatic index_type next_index(input index_type idx, input cfg_type cfg);
      index_type res;
      res = idx;
      if (!idx.part) begin
         res.part = 1'b1;
      end else begin
         res.part = 1'b0;
         if (rx_wraps(idx, cfg)) begin
            res.rx = 2'd0;
            if (tx_wraps(idx, cfg)) begin
               res.tx = 2'd0;
               if (tone_wraps(idx, cfg)) res.tone = 7'd0;
               else res.tone = idx.tone + 7'd1;
            end else begin
               res.tx = idx.tx + 2'd1;
            end
         end else begin
            res.rx = idx.rx + 2'd1;
         end
      end
      return res;
   endfunction

endpackage

// ----- design/csi_tbu_req_if.sv -----
// csi_tbu_req_if: input channel carrying payload words and the packet start mark
// depends on nothing

interface csi_tbu_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] payload_word;
   logic        packet_start;

   modport source (output valid, output payload_word, output packet_start, input ready);
   modport sink   (input valid, input payload_word, input packet_start, output ready);
endinterface

// ----- design/csi_tbu_rsp_if.sv -----
// csi_tbu_rsp_if: result channel carrying one tagged sample component per item
// depends on nothing

interface csi_tbu_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [9:0] sample_value;
   logic              is_real_part;
   logic [1:0]        rx_index;
   logic [1:0]        tx_index;
   logic [6:0]        tone_index;
   logic              last_of_packet;

   modport source (output valid, output sample_value, output is_real_part, output rx_index,
                   output tx_index, output tone_index, output last_of_packet, input ready);
   modport sink   (input valid, input sample_value, input is_real_part, input rx_index,
                   input tx_index, input tone_index, input last_of_packet, output ready);
endinterface

// ----- design/csi_tbu_csr.sv -----
// csi_tbu_csr: register file for antenna and tone counts behind the apb-style port
// depends on csi_tbu_pkg

module csi_tbu_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [csi_tbu_pkg::ADDR_BITS-1:0]    paddr,
   input  logic [csi_tbu_pkg::DATA_BITS-1:0]    pwdata,
   output logic [csi_tbu_pkg::DATA_BITS-1:0]    prdata,
   output logic                                 pready,
   output csi_tbu_pkg::cfg_type                 cfg
);

   csi_tbu_pkg::cfg_type       cfg_ff;
   csi_tbu_pkg::cfg_type       cfg_in;
   csi_tbu_pkg::reg_index_type reg_index;
   logic                       wr_en;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign reg_index = csi_tbu_pkg::reg_index_type'(paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            csi_tbu_pkg::REG_RX_ANTENNAS: cfg_in.rx_antennas = pwdata[1:0];
            csi_tbu_pkg::REG_TX_ANTENNAS: cfg_in.tx_antennas = pwdata[1:0];
            csi_tbu_pkg::REG_TONE_COUNT:  cfg_in.tone_count  = pwdata[6:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         csi_tbu_pkg::REG_RX_ANTENNAS: prdata = {30'd0, cfg_ff.rx_antennas};
         csi_tbu_pkg::REG_TX_ANTENNAS: prdata = {30'd0, cfg_ff.tx_antennas};
         csi_tbu_pkg::REG_TONE_COUNT:  prdata = {25'd0, cfg_ff.tone_count};
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rx_antennas <= csi_tbu_pkg::RESET_RX_ANTENNAS;
         cfg_ff.tx_antennas <= csi_tbu_pkg::RESET_TX_ANTENNAS;
         cfg_ff.tone_count  <= csi_tbu_pkg::RESET_TONE_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/csi_tbu_core.sv -----
// csi_tbu_core: bit window and index state, cuts up to two samples from each word
// depends on csi_tbu_pkg

module csi_tbu_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [15:0]           payload_word,
   input  logic                  packet_start,
   input  csi_tbu_pkg::cfg_type  cfg,
   output csi_tbu_pkg::push_type push
);

   localparam int WB = csi_tbu_pkg::WINDOW_BITS;
   localparam int SB = csi_tbu_pkg::SAMPLE_BITS;
   localparam int FB = csi_tbu_pkg::FILL_BITS;

   logic [WB-1:0]          window_ff, window_in;
   logic [FB-1:0]          fill_ff, fill_in;
   csi_tbu_pkg::index_type idx_ff, idx_in;
   logic                   done_ff, done_in;

   logic [WB-1:0]          base_window, merged;
   logic [FB-1:0]          base_fill, fill_word;
   csi_tbu_pkg::index_type base_idx, idx1, idx2;
   logic                   base_done, last0, last1, emit0, emit1;

   always_comb begin
      base_window = packet_start ? '0 : window_ff;
      base_fill   = packet_start ? '0 : fill_ff;
      base_idx    = packet_start ? '0 : idx_ff;
      base_done   = packet_start ? 1'b0 : done_ff;

      merged    = base_window | (WB'(payload_word) << base_fill);
      fill_word = base_fill + FB'(csi_tbu_pkg::WORD_BITS);

      emit0 = !base_done && (fill_word >= FB'(SB));
      last0 = csi_tbu_pkg::is_last(base_idx, cfg);
      idx1  = csi_tbu_pkg::next_index(base_idx, cfg);
      emit1 = emit0 && !last0 && (fill_word >= FB'(2 * SB));
      last1 = csi_tbu_pkg::is_last(idx1, cfg);
      idx2  = csi_tbu_pkg::next_index(idx1, cfg);

      push.push0                     = accept && emit0;
      push.push1                     = accept && emit1;
      push.item0.sample_value        = merged[SB-1:0];
      push.item0.is_real_part        = base_idx.part;
      push.item0.rx_index            = base_idx.rx;
      push.item0.tx_index            = base_idx.tx;
      push.item0.tone_index          = base_idx.tone;
      push.item0.last_of_packet      = last0;
      push.item1.sample_value        = merged[2*SB-1:SB];
      push.item1.is_real_part        = idx1.part;
      push.item1.rx_index            = idx1.rx;
      push.item1.tx_index            = idx1.tx;
      push.item1.tone_index          = idx1.tone;
      push.item1.last_of_packet      = last1;

      window_in = window_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      done_in   = done_ff;
      if (accept) begin
         if (base_done) begin
            window_in = base_window;
            fill_in   = base_fill;
            idx_in    = base_idx;
            done_in   = 1'b1;
         end else if (emit1) begin
            idx_in = idx2;
            if (last1) begin
               window_in = '0;
               fill_in   = '0;
               done_in   = 1'b1;
            end else begin
               window_in = merged >> (2 * SB);
               fill_in   = fill_word - FB'(2 * SB);
               done_in   = 1'b0;
            end
         end else if (emit0) begin
            idx_in = idx1;
            if (last0) begin
               window_in = '0;
               fill_in   = '0;
               done_in   = 1'b1;
            end else begin
               window_in = merged >> SB;
               fill_in   = fill_word - FB'(SB);
               done_in   = 1'b0;
            end
         end else begin
            window_in = merged;
            fill_in   = fill_word;
            idx_in    = base_idx;
            done_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fill_ff   <= '0;
         idx_ff    <= '0;
         done_ff   <= 1'b1;
      end else begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
         idx_ff    <= idx_in;
         done_ff   <= done_in;
      end
   end

endmodule

// ----- design/csi_tbu_queue.sv -----
// csi_tbu_queue: four-entry result queue, takes up to two items per cycle, gives one
// depends on csi_tbu_pkg

module csi_tbu_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  csi_tbu_pkg::push_type   push,
   input  logic                    pop,
   output csi_tbu_pkg::result_type head,
   output logic                    not_empty,
   output logic                    has_room
);

   localparam int PB = csi_tbu_pkg::QPTR_BITS;
   localparam int CB = csi_tbu_pkg::QCNT_BITS;

   csi_tbu_pkg::result_type entry_ff [csi_tbu_pkg::QUEUE_DEPTH];
   logic [PB-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CB-1:0]           count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PB'(push.push0) + PB'(push.push1);
      rd_ptr_in = rd_ptr_ff + PB'(pop);
      count_in  = count_ff + CB'(push.push0) + CB'(push.push1) - CB'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push0) entry_ff[wr_ptr_ff] <= push.item0;
      if (push.push1) entry_ff[wr_ptr_ff + PB'(1)] <= push.item1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign has_room  = count_ff <= CB'(csi_tbu_pkg::QUEUE_DEPTH - 2);

endmodule

// ----- design/csi_ten_bit_unpacker.sv -----
// csi_ten_bit_unpacker: top level, unpacks 16-bit payload words into signed 10-bit samples
// depends on csi_tbu_pkg, csi_tbu_req_if, csi_tbu_rsp_if, csi_tbu_csr, csi_tbu_core, csi_tbu_queue
// with the queue empty, a word's first sample is on rsp in the cycle after its acceptance
// throughput: a word a cycle while the queue has room, two-sample words included
// reset: synchronous, clears window, indices and queue; words are ignored until a packet start
//   and the counts return to one receive, one transmit antenna and 114 tones

module csi_ten_bit_unpacker (
   input  logic                              clock,
   input  logic                              reset,
   csi_tbu_req_if.sink                       req,
   csi_tbu_rsp_if.source                     rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [csi_tbu_pkg::ADDR_BITS-1:0] paddr,
   input  logic [csi_tbu_pkg::DATA_BITS-1:0] pwdata,
   output logic [csi_tbu_pkg::DATA_BITS-1:0] prdata,
   output logic                              pready
);

   csi_tbu_pkg::cfg_type    cfg;
   csi_tbu_pkg::push_type   push;
   csi_tbu_pkg::result_type head;
   logic                    has_room, not_empty, accept, pop;

   assign req.ready = has_room;
   assign accept    = req.valid && has_room;
   assign pop       = rsp.ready && not_empty;

   csi_tbu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   csi_tbu_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .payload_word (req.payload_word),
      .packet_start (req.packet_start),
      .cfg          (cfg),
      .push         (push)
   );

   csi_tbu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .has_room  (has_room)
   );

   assign rsp.valid          = not_empty;
   assign rsp.sample_value   = head.sample_value;
   assign rsp.is_real_part   = head.is_real_part;
   assign rsp.rx_index       = head.rx_index;
   assign rsp.tx_index       = head.tx_index;
   assign rsp.tone_index     = head.tone_index;
   assign rsp.last_of_packet = head.last_of_packet;

endmodule

// ----- design/csi_tbu_checker.sv -----
// csi_tbu_checker: port-level assertions for the unpacker, with its bind statement
// depends on csi_ten_bit_unpacker ports only

module csi_tbu_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_is_real_part,
   input logic rsp_last_of_packet
);

   // held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // input only backs up when results are waiting
   a_stall_cause: assert property (@(posedge clock)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

   a_last_real: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_packet |-> rsp_is_real_part)
      else $error("last item of packet is not a real part");

endmodule

bind csi_ten_bit_unpacker csi_tbu_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_is_real_part   (rsp.is_real_part),
   .rsp_last_of_packet (rsp.last_of_packet)
);
